/* sv/pplr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pplr_pkg
// Types and constants shared by the particle pool retire block.
// ----------------------------------------------------------------------------
package pplr_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;

   localparam logic [1:0] ACT_SPAWN = 2'd0;
   localparam logic [1:0] ACT_TICK  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;

   // datapath operations issued by the controller
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_DONE  = 3'd1; // tick finished, answer
   localparam logic [2:0] OP_TREAD = 3'd2; // read slot under scan
   localparam logic [2:0] OP_KEEP  = 3'd3; // write back aged record, advance
   localparam logic [2:0] OP_DROP  = 3'd4; // retire last live record
   localparam logic [2:0] OP_PULL  = 3'd5; // retire, fetch last live record
   localparam logic [2:0] OP_COPY  = 3'd6; // write fetched record into hole
   localparam logic [2:0] OP_RDOUT = 3'd7; // answer a read

   typedef struct packed {
      logic [1:0]  action;
      logic [10:0] batch_count;
      logic signed [31:0] lifetime;
      logic [30:0] tick_delta;
      logic [63:0] position_xy;
      logic [31:0] position_z;
      logic [63:0] velocity_xy;
      logic [31:0] velocity_z;
      logic [63:0] color_rg;
      logic [63:0] color_ba;
      logic [31:0] particle_size;
      logic [9:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] accepted_count;
      logic [10:0] live_total;
      logic signed [31:0] remaining_life;
      logic [63:0] out_position_xy;
      logic [31:0] out_position_z;
      logic [63:0] out_velocity_xy;
      logic [31:0] out_velocity_z;
      logic [63:0] out_color_rg;
      logic [63:0] out_color_ba;
      logic [31:0] out_particle_size;
   } rsp_type;

   typedef struct packed {
      logic [31:0] life;
      logic [63:0] pos_xy;
      logic [31:0] pos_z;
      logic [63:0] vel_xy;
      logic [31:0] vel_z;
      logic [63:0] color_rg;
      logic [63:0] color_ba;
      logic [31:0] size;
   } rec_type;

   typedef struct packed {
      logic       accept;
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic read_ok;
      logic dt_zero;
      logic scan_more;
      logic expired;
      logic scan_last;
      logic rsp_block;
   } stat_type;

endpackage
`default_nettype wire

/* sv/pplr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pplr_ctrl
// Sequencer: accepts words, walks the live region during a tick.
// ----------------------------------------------------------------------------
module pplr_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire  [1:0]              req_action,
   output logic                    req_stall,
   input  wire pplr_pkg::stat_type stat,
   output pplr_pkg::cmd_type       cmd
);
   import pplr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TRD   = 3'd1;
   localparam logic [2:0] S_TEV   = 3'd2;
   localparam logic [2:0] S_TCP   = 3'd3;
   localparam logic [2:0] S_RWAIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE) | stat.rsp_block;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = accept;
      cmd.op     = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_TICK) state_in = S_TRD;
               else if (req_action == ACT_READ && stat.read_ok) state_in = S_RWAIT;
            end
         end
         S_TRD: begin
            if (stat.dt_zero | ~stat.scan_more) begin
               cmd.op   = OP_DONE;
               state_in = S_IDLE;
            end else begin
               cmd.op   = OP_TREAD;
               state_in = S_TEV;
            end
         end
         S_TEV: begin
            state_in = S_TRD;
            if (!stat.expired) cmd.op = OP_KEEP;
            else if (stat.scan_last) cmd.op = OP_DROP;
            else begin
               cmd.op   = OP_PULL;
               state_in = S_TCP;
            end
         end
         S_TCP: begin
            cmd.op   = OP_COPY;
            state_in = S_TRD;
         end
         S_RWAIT: begin
            cmd.op   = OP_RDOUT;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

/* sv/pplr_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pplr_dp
// Record memory, pool counters, batch tracking and response register.
// ----------------------------------------------------------------------------
module pplr_dp (
   input  wire                     clock,
   input  wire                     reset,
   input  wire pplr_pkg::req_type  req_word,
   input  wire pplr_pkg::cmd_type  cmd,
   output pplr_pkg::stat_type      stat,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output pplr_pkg::rsp_type       rsp_word
);
   import pplr_pkg::*;

   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   rec_type mem [CAPACITY];
   rec_type rdata_ff;

   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] filled_ff, filled_in;
   logic             rej_ff, rej_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [30:0]      dt_ff, dt_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_load;

   logic             we, re;
   logic [ADDR_W-1:0] waddr, raddr;
   rec_type          wdata;

   logic             open_b, rej_e;
   logic [CNT_W-1:0] left_e, filled_e, filled_n, slot, live_m1;
   logic [32:0]      aged;
   rec_type          aged_rec, in_rec;

   assign open_b   = (left_ff == '0);
   assign left_e   = open_b ? req_word.batch_count : left_ff;
   assign filled_e = open_b ? '0 : filled_ff;
   assign rej_e    = open_b ? (req_word.batch_count > (CAP_C - live_ff)) : rej_ff;
   assign filled_n = filled_e + 1'b1;
   assign slot     = live_ff + filled_e;
   assign live_m1  = live_ff - 1'b1;

   assign aged = {rdata_ff.life[31], rdata_ff.life} - {2'b00, dt_ff};
   always_comb begin
      aged_rec      = rdata_ff;
      aged_rec.life = aged[31:0];
      in_rec.life     = req_word.lifetime;
      in_rec.pos_xy   = req_word.position_xy;
      in_rec.pos_z    = req_word.position_z;
      in_rec.vel_xy   = req_word.velocity_xy;
      in_rec.vel_z    = req_word.velocity_z;
      in_rec.color_rg = req_word.color_rg;
      in_rec.color_ba = req_word.color_ba;
      in_rec.size     = req_word.particle_size;
   end

   assign stat.read_ok   = {1'b0, req_word.read_index} < live_ff;
   assign stat.dt_zero   = (dt_ff == '0);
   assign stat.scan_more = idx_ff < live_ff;
   assign stat.expired   = aged[32] | (aged == '0);
   assign stat.scan_last = (idx_ff == live_m1);
   assign stat.rsp_block = rsp_valid_ff & rsp_stall;

   always_comb begin
      live_in   = live_ff;
      left_in   = left_ff;
      filled_in = filled_ff;
      rej_in    = rej_ff;
      idx_in    = idx_ff;
      dt_in     = dt_ff;
      rsp_in    = '0;
      rsp_load  = 1'b0;
      we        = 1'b0;
      re        = 1'b0;
      waddr     = idx_ff[ADDR_W-1:0];
      raddr     = idx_ff[ADDR_W-1:0];
      wdata     = rdata_ff;

      if (cmd.accept) begin
         unique case (req_word.action)
            ACT_SPAWN: begin
               if (open_b && req_word.batch_count == '0) begin
                  rsp_load = 1'b1;
               end else begin
                  if (!rej_e) begin
                     we    = 1'b1;
                     waddr = slot[ADDR_W-1:0];
                     wdata = in_rec;
                  end
                  left_in   = left_e - 1'b1;
                  filled_in = filled_n;
                  rej_in    = rej_e;
                  if (left_e == CNT_W'(1)) begin
                     rsp_load  = 1'b1;
                     filled_in = '0;
                     rej_in    = 1'b0;
                     if (rej_e) rsp_in.status = ST_EXHAUSTED;
                     else begin
                        live_in               = live_ff + filled_n;
                        rsp_in.accepted_count = filled_n;
                     end
                  end
               end
            end
            ACT_TICK: begin
               left_in   = '0;
               filled_in = '0;
               rej_in    = 1'b0;
               idx_in    = '0;
               dt_in     = req_word.tick_delta;
            end
            ACT_READ: begin
               if (stat.read_ok) begin
                  re    = 1'b1;
                  raddr = req_word.read_index;
               end else begin
                  rsp_load      = 1'b1;
                  rsp_in.status = ST_RANGE;
               end
            end
            default: ;
         endcase
      end

      unique case (cmd.op)
         OP_DONE:  rsp_load = 1'b1;
         OP_TREAD: re = 1'b1;
         OP_KEEP: begin
            we     = 1'b1;
            wdata  = aged_rec;
            idx_in = idx_ff + 1'b1;
         end
         OP_DROP: live_in = live_m1;
         OP_PULL: begin
            live_in = live_m1;
            re      = 1'b1;
            raddr   = live_m1[ADDR_W-1:0];
         end
         OP_COPY: we = 1'b1;
         OP_RDOUT: begin
            rsp_load                 = 1'b1;
            rsp_in.remaining_life    = rdata_ff.life;
            rsp_in.out_position_xy   = rdata_ff.pos_xy;
            rsp_in.out_position_z    = rdata_ff.pos_z;
            rsp_in.out_velocity_xy   = rdata_ff.vel_xy;
            rsp_in.out_velocity_z    = rdata_ff.vel_z;
            rsp_in.out_color_rg      = rdata_ff.color_rg;
            rsp_in.out_color_ba      = rdata_ff.color_ba;
            rsp_in.out_particle_size = rdata_ff.size;
         end
         default: ;
      endcase
      rsp_in.live_total = live_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         left_ff      <= '0;
         filled_ff    <= '0;
         rej_ff       <= 1'b0;
         idx_ff       <= '0;
         dt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         live_ff   <= live_in;
         left_ff   <= left_in;
         filled_ff <= filled_in;
         rej_ff    <= rej_in;
         idx_ff    <= idx_in;
         dt_ff     <= dt_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_live_cap: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CAP_C) else $error("live count above capacity");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall)) else $error("response overwritten");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_KEEP) |=> (idx_ff <= live_ff)) else $error("scan past live region");
`endif

endmodule
`default_nettype wire

/* sv/particle_pool_lifetime_retire.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_lifetime_retire
// Dense particle pool with batch spawn, lifetime aging and swap-remove.
//
// Request words (req_valid/req_stall/req_word) carry spawn, tick or read.
// Spawn words of a batch give one response word on the batch's last word;
// a zero-size batch answers at once. For spawns and rejected/short reads
// the response word is registered at the accept edge. A valid read goes
// through the registered record memory read port before it answers.
// A tick walks live slots through the record memory: each record is read
// and aged; a survivor is written back, a retired one is dropped or
// replaced by the last live record. A zero delta or empty pool is not walked.
// One request word is in work at a time; req_stall is high while a word
// is in work or the response register is full and stalled.
// rsp_word is held while rsp_stall is high. Reset clears the live count
// and batch state; record memory contents are undefined until written.
// ----------------------------------------------------------------------------
module particle_pool_lifetime_retire (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire pplr_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output pplr_pkg::rsp_type      rsp_word
);
   import pplr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pplr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_word.action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   pplr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

/* sim/pplr_checker.sv */
// ----------------------------------------------------------------------------
// pplr_checker
// Watches the request and response channels of the particle pool, predicts
// every response word from its own copy of the pool and compares the words.
// ----------------------------------------------------------------------------
module pplr_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_stall,
   input  pplr_pkg::req_type req_word,
   input  wire               rsp_valid,
   input  wire               rsp_stall,
   input  pplr_pkg::rsp_type rsp_word,
   output int                fail_count,
   output int                pending,
   output int                pool_live
);
   timeunit 1ns;
   timeprecision 1ps;
   import pplr_pkg::*;

   rec_type          pool [CAPACITY];
   int unsigned      live_n;
   int unsigned      batch_left;
   int unsigned      batch_filled;
   bit               batch_reject;
   rsp_type          expected_q [$];

   initial begin
      fail_count = 0;
      pending = 0;
      pool_live = 0;
      live_n = 0;
      batch_left = 0;
      batch_filled = 0;
      batch_reject = 0;
   end

   function automatic rsp_type answer(logic [1:0] st, int unsigned acc);
      rsp_type r;
      r = '0;
      r.status = st;
      r.accepted_count = acc[10:0];
      r.live_total = live_n[10:0];
      return r;
   endfunction

   task automatic predict(req_type w);
      rsp_type     r;
      rec_type     rec;
      int unsigned i;
      longint      v;
      longint      dt;
      case (w.action)
         ACT_SPAWN: begin
            if (batch_left == 0) begin
               if (w.batch_count == '0) begin
                  expected_q.push_back(answer(ST_OK, 0));
                  return;
               end
               batch_left = 32'(w.batch_count);
               batch_filled = 0;
               batch_reject = 32'(w.batch_count) > CAPACITY - live_n;
            end
            if (!batch_reject && live_n + batch_filled < CAPACITY) begin
               rec.life = w.lifetime;
               rec.pos_xy = w.position_xy;
               rec.pos_z = w.position_z;
               rec.vel_xy = w.velocity_xy;
               rec.vel_z = w.velocity_z;
               rec.color_rg = w.color_rg;
               rec.color_ba = w.color_ba;
               rec.size = w.particle_size;
               pool[live_n + batch_filled] = rec;
            end
            batch_filled++;
            batch_left--;
            if (batch_left != 0) return;
            if (batch_reject) begin
               batch_reject = 0;
               batch_filled = 0;
               expected_q.push_back(answer(ST_EXHAUSTED, 0));
            end else begin
               live_n += batch_filled;
               expected_q.push_back(answer(ST_OK, batch_filled));
               batch_filled = 0;
            end
         end
         ACT_TICK: begin
            dt = longint'(w.tick_delta);
            batch_left = 0;
            batch_filled = 0;
            batch_reject = 0;
            if (dt != 0) begin
               i = 0;
               while (i < live_n) begin
                  v = longint'($signed(pool[i].life)) - dt;
                  if (v <= 0) begin
                     live_n--;
                     // swapped-in record is examined at the same slot
                     if (i != live_n) pool[i] = pool[live_n];
                  end else begin
                     pool[i].life = v[31:0];
                     i++;
                  end
               end
            end
            expected_q.push_back(answer(ST_OK, 0));
         end
         ACT_READ: begin
            if (32'(w.read_index) >= live_n) begin
               expected_q.push_back(answer(ST_RANGE, 0));
            end else begin
               r = answer(ST_OK, 0);
               rec = pool[w.read_index];
               r.remaining_life = rec.life;
               r.out_position_xy = rec.pos_xy;
               r.out_position_z = rec.pos_z;
               r.out_velocity_xy = rec.vel_xy;
               r.out_velocity_z = rec.vel_z;
               r.out_color_rg = rec.color_rg;
               r.out_color_ba = rec.color_ba;
               r.out_particle_size = rec.size;
               expected_q.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare(rsp_type a);
      rsp_type e;
      if (expected_q.size() == 0) begin
         $error("unexpected response word: %p", a);
         fail_count++;
         return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, a.status);
         fail_count++;
      end
      if (a.accepted_count !== e.accepted_count) begin
         $error("accepted_count: expected %0d, actual %0d", e.accepted_count,
                a.accepted_count);
         fail_count++;
      end
      if (a.live_total !== e.live_total) begin
         $error("live_total: expected %0d, actual %0d", e.live_total, a.live_total);
         fail_count++;
      end
      if (a.remaining_life !== e.remaining_life) begin
         $error("remaining_life: expected %h, actual %h", e.remaining_life,
                a.remaining_life);
         fail_count++;
      end
      if (a.out_position_xy !== e.out_position_xy) begin
         $error("out_position_xy: expected %h, actual %h", e.out_position_xy,
                a.out_position_xy);
         fail_count++;
      end
      if (a.out_position_z !== e.out_position_z) begin
         $error("out_position_z: expected %h, actual %h", e.out_position_z,
                a.out_position_z);
         fail_count++;
      end
      if (a.out_velocity_xy !== e.out_velocity_xy) begin
         $error("out_velocity_xy: expected %h, actual %h", e.out_velocity_xy,
                a.out_velocity_xy);
         fail_count++;
      end
      if (a.out_velocity_z !== e.out_velocity_z) begin
         $error("out_velocity_z: expected %h, actual %h", e.out_velocity_z,
                a.out_velocity_z);
         fail_count++;
      end
      if (a.out_color_rg !== e.out_color_rg) begin
         $error("out_color_rg: expected %h, actual %h", e.out_color_rg,
                a.out_color_rg);
         fail_count++;
      end
      if (a.out_color_ba !== e.out_color_ba) begin
         $error("out_color_ba: expected %h, actual %h", e.out_color_ba,
                a.out_color_ba);
         fail_count++;
      end
      if (a.out_particle_size !== e.out_particle_size) begin
         $error("out_particle_size: expected %h, actual %h", e.out_particle_size,
                a.out_particle_size);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) compare(rsp_word);
         if (req_valid === 1'b1 && req_stall === 1'b0) predict(req_word);
      end
      pending = expected_q.size();
      pool_live = int'(live_n);
   end

endmodule

/* sim/tb_particle_pool_lifetime_retire.sv */
// ----------------------------------------------------------------------------
// tb_particle_pool_lifetime_retire
// Drives spawn batches, ticks and reads into the particle pool with random
// gaps and response stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_particle_pool_lifetime_retire;
   timeunit 1ns;
   timeprecision 1ps;
   import pplr_pkg::*;

   // action code with no meaning
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;
   int      fail_count;
   int      pending;
   int      pool_live;

   int      tx_idle_pct;
   int      rx_idle_pct;
   int      words_sent;

   particle_pool_lifetime_retire u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   pplr_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending(pending), .pool_live(pool_live)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   initial begin
      #100ms;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [31:0] pick_life();
      int r;
      r = $urandom_range(99);
      if (r < 65) return $urandom_range(1, 32'h0004_0000);
      if (r < 75) return -$urandom_range(0, 32'h0001_0000);
      return $urandom;
   endfunction

   function automatic logic [30:0] pick_delta();
      int r;
      r = $urandom_range(99);
      if (r < 15) return '0;
      if (r < 85) return 31'($urandom_range(1, 32'h0001_8000));
      return 31'($urandom);
   endfunction

   function automatic req_type spawn_word(int n);
      req_type w;
      w.action = ACT_SPAWN;
      w.batch_count = n[10:0];
      w.lifetime = pick_life();
      w.tick_delta = 31'($urandom);
      w.position_xy = {$urandom, $urandom};
      w.position_z = $urandom;
      w.velocity_xy = {$urandom, $urandom};
      w.velocity_z = $urandom;
      w.color_rg = {$urandom, $urandom};
      w.color_ba = {$urandom, $urandom};
      w.particle_size = $urandom;
      w.read_index = 10'($urandom);
      return w;
   endfunction

   task automatic send(req_type w);
      // each idle cycle drawn on its own
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic idle_wait();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic spawn_batch(int n, int k);
      // k words actually sent; fewer than n leaves the batch open
      for (int i = 0; i < k; i++) send(spawn_word(n));
   endtask

   task automatic tick(logic [30:0] dt);
      req_type w;
      w = spawn_word(0);
      w.action = ACT_TICK;
      w.tick_delta = dt;
      send(w);
   endtask

   task automatic read_slot(logic [9:0] idx);
      req_type w;
      w = spawn_word(0);
      w.action = ACT_READ;
      w.read_index = idx;
      send(w);
   endtask

   task automatic random_phase(int count);
      int      r;
      int      n;
      req_type w;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            n = $urandom_range(1, 6);
            spawn_batch(n, n);
         end else if (r < 65) begin
            if (pool_live > 0 && $urandom_range(9) < 8)
               read_slot(10'($urandom_range(pool_live - 1)));
            else
               read_slot(10'($urandom));
         end else if (r < 82) begin
            tick(pick_delta());
         end else if (r < 88) begin
            // batch broken by a read, then by a tick or by more spawn words
            n = $urandom_range(2, 6);
            spawn_batch(n, $urandom_range(1, n - 1));
            read_slot(10'($urandom_range(3)));
            if ($urandom_range(1)) tick(pick_delta());
            else spawn_batch(n, n);
         end else if (r < 94) begin
            w = spawn_word(0);
            w.action = ACT_UNUSED;
            send(w);
         end else begin
            send(spawn_word(0));
         end
      end
   endtask

   initial begin
      req_type w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      tx_idle_pct = 12;
      rx_idle_pct = 62;
      words_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty pool, extremes, open-batch cases
      send(spawn_word(0));
      read_slot(10'd0);
      read_slot(10'h3FF);
      w = spawn_word(3);
      w.lifetime = 32'sh7FFF_FFFF;
      w.position_xy = '1; w.velocity_xy = '1; w.color_rg = '1; w.color_ba = '1;
      w.position_z = '1; w.velocity_z = '1; w.particle_size = '1;
      send(w);
      w = spawn_word(3);
      w.lifetime = 32'sh8000_0000;
      w.position_xy = '0; w.velocity_xy = '0; w.color_rg = '0; w.color_ba = '0;
      w.position_z = '0; w.velocity_z = '0; w.particle_size = '0;
      send(w);
      w.lifetime = 32'sh0000_0001;
      send(w);
      read_slot(10'd0);
      read_slot(10'd1);
      read_slot(10'd2);
      read_slot(10'd3);
      tick('0);
      tick(31'd1);
      read_slot(10'd0);
      w = spawn_word(0);
      w.action = ACT_UNUSED;
      send(w);
      spawn_batch(4, 2);
      read_slot(10'd0);
      tick(31'd1);
      read_slot(10'd1);
      tick(31'h7FFF_FFFF);
      read_slot(10'd0);

      random_phase(100);

      // fill the pool completely, then overflow it
      idle_wait();
      tx_idle_pct = 62;
      rx_idle_pct = 12;
      tick(31'h7FFF_FFFF);
      spawn_batch(1024, 1024);
      read_slot(10'h3FF);
      spawn_batch(1, 1);
      tick(31'd1);
      tick(31'h7FFF_FFFF);
      spawn_batch(1025, 3);

      random_phase(100);

      idle_wait();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_phase(100);

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/pplr_pkg.sv
sv/pplr_ctrl.sv
sv/pplr_dp.sv
sv/particle_pool_lifetime_retire.sv
sim/pplr_checker.sv
sim/tb_particle_pool_lifetime_retire.sv
